FILE: src/kca_pkg.sv
`default_nettype none

package kca_pkg;

   // Default configuration of the table.
   localparam int DEF_ENTRIES    = 128;
   localparam int DEF_KEY_BITS   = 64;
   localparam int DEF_COUNT_BITS = 16;
   localparam int DEF_SUM_BITS   = 32;

   // Widths of the fields on the channels.
   localparam int OPCODE_W = 1;
   localparam int KEY_W    = 64;
   localparam int COUNT_W  = 16;
   localparam int RIDX_W   = 7;
   localparam int STATUS_W = 2;
   localparam int EIDX_W   = 7;
   localparam int ESUM_W   = 32;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD  = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ADD_MERGED   = 2'd0,
      ADD_INSERTED = 2'd1,
      ADD_FULL     = 2'd2
   } add_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept_add;
      logic accept_read;
      logic scan_step;
      logic res_read;
      logic res_merge;
      logic res_insert;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic hit;
      logic at_end;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

FILE: src/kca_dp.sv
`default_nettype none

module kca_dp #(
   parameter int ENTRIES    = kca_pkg::DEF_ENTRIES,
   parameter int KEY_BITS   = kca_pkg::DEF_KEY_BITS,
   parameter int COUNT_BITS = kca_pkg::DEF_COUNT_BITS,
   parameter int SUM_BITS   = kca_pkg::DEF_SUM_BITS
) (
   input  wire                            clock,
   input  wire                            reset,
   input  kca_pkg::cmd_type               cmd,
   output kca_pkg::status_type            status,
   input  wire [kca_pkg::KEY_W-1:0]       item_key,
   input  wire [kca_pkg::COUNT_W-1:0]     item_count,
   input  wire [kca_pkg::RIDX_W-1:0]      read_index,
   input  wire                            rsp_ready,
   output logic                           rsp_valid,
   output logic [kca_pkg::STATUS_W-1:0]   add_status,
   output logic [kca_pkg::EIDX_W-1:0]     entry_index,
   output logic [kca_pkg::KEY_W-1:0]      entry_key,
   output logic [kca_pkg::ESUM_W-1:0]     entry_sum,
   output logic                           entry_valid,
   output logic                           sum_nonzero
);
   import kca_pkg::*;

   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int MEM_W    = KEY_BITS + SUM_BITS;
   localparam int CNT_KEEP = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
   localparam int ACC_W    = ((SUM_BITS > CNT_KEEP) ? SUM_BITS : CNT_KEEP) + 1;

   // Key and sum of one entry, side by side in one word.
   logic [MEM_W-1:0]    mem [ENTRIES];
   logic [MEM_W-1:0]    rd_data_ff;

   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_KEEP-1:0] cnt_ff;
   logic [RIDX_W-1:0]   ridx_ff;
   logic                rd_ok_ff, rd_ok_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [IDX_W-1:0]    cmp_ff, cmp_in;
   logic                dv_ff, dv_in;
   logic [CNT_W-1:0]    used_ff, used_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [EIDX_W-1:0]   eidx_ff;
   logic [KEY_W-1:0]    ekey_ff;
   logic [ESUM_W-1:0]   esum_ff;
   logic                evalid_ff;
   logic                enz_ff;

   logic [IDX_W+RIDX_W-1:0] ridx_ext;
   logic [CNT_W+RIDX_W-1:0] ridx_cmp;
   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [KEY_BITS-1:0] rd_key;
   logic [SUM_BITS-1:0] rd_sum;
   logic                table_full;
   logic [SUM_BITS-1:0] acc_a;
   logic [ACC_W-1:0]    acc_sum;
   logic [SUM_BITS-1:0] new_sum;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [MEM_W-1:0]    wr_data;
   logic                res_load;
   add_status_type      res_status;
   logic [IDX_W-1:0]    res_idx;
   logic [KEY_BITS-1:0] res_key;
   logic [SUM_BITS-1:0] res_sum;
   logic                res_valid;
   logic [IDX_W+EIDX_W-1:0]  idx_wide;
   logic [SUM_BITS+ESUM_W-1:0] sum_wide;

   assign ridx_ext = (IDX_W + RIDX_W)'(read_index);
   assign ridx_cmp = (CNT_W + RIDX_W)'(read_index);

   assign rd_en   = cmd.accept_add | cmd.accept_read | cmd.scan_step;
   always_comb begin
      if (cmd.accept_read) begin
         rd_addr = ridx_ext[IDX_W-1:0];
      end else if (cmd.scan_step) begin
         rd_addr = scan_ff[IDX_W-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   assign rd_key = rd_data_ff[MEM_W-1:SUM_BITS];
   assign rd_sum = rd_data_ff[SUM_BITS-1:0];

   assign status.hit      = dv_ff && (rd_key == key_ff);
   assign status.at_end   = !dv_ff || ((CNT_W'(cmp_ff) + 1'b1) == used_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign table_full = (used_ff == CNT_W'(ENTRIES));

   // Shared saturating adder: existing sum on a merge, zero on an insert.
   assign acc_a   = cmd.res_merge ? rd_sum : '0;
   assign acc_sum = ACC_W'(acc_a) + ACC_W'(cnt_ff);
   assign new_sum = (acc_sum[ACC_W-1:SUM_BITS] != '0) ? {SUM_BITS{1'b1}}
                                                       : acc_sum[SUM_BITS-1:0];

   assign wr_en   = cmd.res_merge | (cmd.res_insert & !table_full);
   assign wr_addr = cmd.res_merge ? cmp_ff : used_ff[IDX_W-1:0];
   assign wr_data = {(cmd.res_merge ? rd_key : key_ff), new_sum};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      rd_ok_in = rd_ok_ff;
      scan_in  = scan_ff;
      cmp_in   = cmp_ff;
      dv_in    = dv_ff;
      used_in  = used_ff;
      if (cmd.accept_read) begin
         rd_ok_in = ridx_cmp < (CNT_W + RIDX_W)'(used_ff);
      end
      if (cmd.accept_add) begin
         scan_in = CNT_W'(1);
         cmp_in  = '0;
         dv_in   = (used_ff != '0);
      end
      if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
         cmp_in  = scan_ff[IDX_W-1:0];
         dv_in   = (scan_ff < used_ff);
      end
      if (cmd.res_insert && !table_full) begin
         used_in = used_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_add || cmd.accept_read) begin
         key_ff  <= item_key[KEY_BITS-1:0];
         cnt_ff  <= item_count[CNT_KEEP-1:0];
         ridx_ff <= read_index;
      end
      rd_ok_ff <= rd_ok_in;
      scan_ff  <= scan_in;
      cmp_ff   <= cmp_in;
      dv_ff    <= dv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // Result selection.
   assign res_load = cmd.res_read | cmd.res_merge | cmd.res_insert;

   always_comb begin
      res_status = ADD_MERGED;
      res_idx    = '0;
      res_key    = '0;
      res_sum    = '0;
      res_valid  = 1'b0;
      if (cmd.res_read) begin
         res_valid = rd_ok_ff;
         if (rd_ok_ff) begin
            res_key = rd_key;
            res_sum = rd_sum;
         end
      end else if (cmd.res_merge) begin
         res_idx   = cmp_ff;
         res_key   = rd_key;
         res_sum   = new_sum;
         res_valid = 1'b1;
      end else if (cmd.res_insert) begin
         if (table_full) begin
            res_status = ADD_FULL;
         end else begin
            res_status = ADD_INSERTED;
            res_idx    = used_ff[IDX_W-1:0];
            res_key    = key_ff;
            res_sum    = new_sum;
            res_valid  = 1'b1;
         end
      end
   end

   assign idx_wide = (IDX_W + EIDX_W)'(res_idx);
   assign sum_wide = (SUM_BITS + ESUM_W)'(res_sum);

   always_ff @(posedge clock) begin
      if (res_load) begin
         status_ff <= res_status;
         eidx_ff   <= cmd.res_read ? ridx_ff : idx_wide[EIDX_W-1:0];
         ekey_ff   <= KEY_W'(res_key);
         esum_ff   <= sum_wide[ESUM_W-1:0];
         evalid_ff <= res_valid;
         enz_ff    <= res_valid && (res_sum != '0);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign add_status  = status_ff;
   assign entry_index = eidx_ff;
   assign entry_key   = ekey_ff;
   assign entry_sum   = esum_ff;
   assign entry_valid = evalid_ff;
   assign sum_nonzero = enz_ff;

endmodule

`default_nettype wire

FILE: src/kca_ctrl.sv
`default_nettype none

module kca_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_opcode,
   output logic                 req_ready,
   input  kca_pkg::status_type  status,
   output kca_pkg::cmd_type     cmd
);
   import kca_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == OP_READ) begin
                  cmd.accept_read = 1'b1;
                  state_in        = ST_READ;
               end else begin
                  cmd.accept_add = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_READ: begin
            if (status.out_free) begin
               cmd.res_read = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // The entry in the read register is compared each cycle; the scan steps on
            // regardless, and only the merge or insert waits while the result register is still occupied.
            if (status.hit) begin
               if (status.out_free) begin
                  cmd.res_merge = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (status.at_end) begin
               if (status.out_free) begin
                  cmd.res_insert = 1'b1;
                  state_in       = ST_IDLE;
               end
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: src/keyed_count_aggregator.sv
`default_nettype none

// Channel   Direction  Fields (from bit 0 up)
// req_      in         opcode, item_key, item_count, read_index
// rsp_      out        add_status, entry_index, entry_key, entry_sum,
//                      entry_valid, sum_nonzero
//
// A read occupies the block from its transfer until its result is loaded. An add
// compares the stored keys one per cycle in insertion order through the single read
// port of the entry memory, so it ends at the entry that it hits, or after the last
// used entry when it inserts or finds the table full.
// Reset clears the entry count, the response valid flag and the control state; the
// memory itself is not cleared, as only entries below the count are ever shown.
// A result waits in the output register while the next item is transferred;
// only the final step of that next item stalls until the register frees up.

module keyed_count_aggregator #(
   parameter int ENTRIES    = kca_pkg::DEF_ENTRIES,
   parameter int KEY_BITS   = kca_pkg::DEF_KEY_BITS,
   parameter int COUNT_BITS = kca_pkg::DEF_COUNT_BITS,
   parameter int SUM_BITS   = kca_pkg::DEF_SUM_BITS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [87:0]  req_tdata,  // opcode, item_key, item_count, read_index
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [111:0] rsp_tdata  // add_status, entry_index, entry_key, entry_sum,
                                   // entry_valid, sum_nonzero, zero fill
);
   import kca_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic                req_opcode;
   logic [KEY_W-1:0]    req_key;
   logic [COUNT_W-1:0]  req_count;
   logic [RIDX_W-1:0]   req_ridx;

   logic [STATUS_W-1:0] add_status;
   logic [EIDX_W-1:0]   entry_index;
   logic [KEY_W-1:0]    entry_key;
   logic [ESUM_W-1:0]   entry_sum;
   logic                entry_valid;
   logic                sum_nonzero;

   // Unpack the request word.
   assign req_opcode = req_tdata[0];
   assign req_key    = req_tdata[64:1];
   assign req_count  = req_tdata[80:65];
   assign req_ridx   = req_tdata[87:81];

   // The controller sequences each transfer: it starts a read or a key scan,
   // steps the scan, and fires the merge, insert or read result when the
   // output register can take it.
   kca_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_opcode (req_opcode),
      .req_ready  (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the entry memory, the entry count, the saturating
   // adder and the result register.
   kca_dp #(
      .ENTRIES    (ENTRIES),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .item_key    (req_key),
      .item_count  (req_count),
      .read_index  (req_ridx),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .add_status  (add_status),
      .entry_index (entry_index),
      .entry_key   (entry_key),
      .entry_sum   (entry_sum),
      .entry_valid (entry_valid),
      .sum_nonzero (sum_nonzero)
   );

   // Pack the response word; the top bits are zero fill.
   assign rsp_tdata = {5'b0, sum_nonzero, entry_valid, entry_sum, entry_key,
                       entry_index, add_status};

endmodule

`default_nettype wire

FILE: tb/keyed_count_aggregator_tb.sv
`default_nettype none

module keyed_count_aggregator_tb;
   import kca_pkg::*;

   // The run is bounded by a cycle count that allows for several times the slowest
   // legal run: every add scanning a full table under the longest stalls and gaps.
   localparam int unsigned LIMIT_CYCLES = 500_000;
   localparam int unsigned DRAIN_CYCLES = 300;
   localparam int unsigned HOLD_AFTER   = 100;
   localparam int unsigned HOLD_CYCLES  = 600;
   localparam int unsigned TABLE_SLOTS  = DEF_ENTRIES;

   // One request as the sender sees it, with the idle cycles it waits before it is offered.
   typedef struct {
      opcode_type        op;
      logic [KEY_W-1:0]  key;
      logic [COUNT_W-1:0] count;
      logic [RIDX_W-1:0] ridx;
      int unsigned       gap;
   } request_type;

   // One response broken into its fields.
   typedef struct packed {
      add_status_type    status;
      logic [EIDX_W-1:0] index;
      logic [KEY_W-1:0]  key;
      logic [ESUM_W-1:0] sum;
      logic              valid;
      logic              nonzero;
   } table_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   wire           req_tready;
   logic [87:0]   req_tdata = '0;   // opcode, item_key, item_count, read_index
   wire           rsp_tvalid;
   logic          rsp_tready = 1'b0;
   wire  [111:0]  rsp_tdata;        // add_status, entry_index, entry_key, entry_sum,
                                    // entry_valid, sum_nonzero, zero fill

   keyed_count_aggregator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Our own copy of the table, advanced once for every request transfer.
   logic [KEY_W-1:0]  tally_keys [TABLE_SLOTS];
   logic [ESUM_W-1:0] tally_sums [TABLE_SLOTS];
   int unsigned       tally_used = 0;

   request_type       pending_items [$];
   table_result_type  expected_results [$];
   logic [KEY_W-1:0]  keys_offered [$];
   request_type       offered;

   logic              req_fired = 1'b0;
   logic              rsp_fired = 1'b0;
   int unsigned       req_wait = 0;
   int unsigned       results_checked = 0;
   int unsigned       errors = 0;
   int unsigned       cycle_count = 0;

   // Receiver pacing.
   logic              hold_done = 1'b0;
   int unsigned       hold_left = 0;
   int unsigned       stall_left = 0;
   int unsigned       quiet_left = 0;

   initial begin : clock_gen
      forever begin
         #5 clock = ~clock;
      end
   end

   // Applies one request to the table copy and returns the response it must produce.
   // A read below the fill level shows the entry; anything else reads as empty. An add
   // scans in insertion order, merges with a saturating sum, or appends, or drops the
   // item when every slot is taken.
   function automatic table_result_type tally_apply(request_type it);
      table_result_type r;
      logic [ESUM_W:0] wide;
      r = '0;
      r.status = ADD_MERGED;
      if (it.op == OP_READ) begin
         r.index = it.ridx;
         if (it.ridx < tally_used) begin
            r.key   = tally_keys[it.ridx];
            r.sum   = tally_sums[it.ridx];
            r.valid = 1'b1;
         end
      end else begin
         r.valid = 1'b1;
         r.index = '1;
         for (int unsigned i = 0; i < tally_used; i++) begin
            if (tally_keys[i] == it.key && r.index == '1 && r.key == '0 && r.status == ADD_MERGED
                && !r.nonzero) begin
               wide = {1'b0, tally_sums[i]} + it.count;
               tally_sums[i] = wide[ESUM_W] ? '1 : wide[ESUM_W-1:0];
               r.index = i[EIDX_W-1:0];
               r.key   = tally_keys[i];
               r.sum   = tally_sums[i];
               r.nonzero = (r.sum != '0);
               r.nonzero = r.nonzero;
               return '{ADD_MERGED, i[EIDX_W-1:0], tally_keys[i], tally_sums[i], 1'b1,
                        tally_sums[i] != '0};
            end
         end
         if (tally_used < TABLE_SLOTS) begin
            tally_keys[tally_used] = it.key;
            tally_sums[tally_used] = ESUM_W'(it.count);
            r.status = ADD_INSERTED;
            r.index  = tally_used[EIDX_W-1:0];
            r.key    = it.key;
            r.sum    = ESUM_W'(it.count);
            tally_used++;
         end else begin
            r = '0;
            r.status = ADD_FULL;
         end
      end
      r.nonzero = r.valid && (r.sum != '0);
      return r;
   endfunction

   task automatic compare_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
         errors++;
      end
   endtask

   task automatic queue_add(logic [KEY_W-1:0] key, logic [COUNT_W-1:0] count, bit paced);
      request_type it;
      it.op    = OP_ADD;
      it.key   = key;
      it.count = count;
      it.ridx  = RIDX_W'($urandom);
      it.gap   = paced ? $urandom_range(0, 14) : 0;
      pending_items.push_back(it);
      keys_offered.push_back(key);
   endtask

   task automatic queue_read(logic [RIDX_W-1:0] ridx, bit paced);
      request_type it;
      it.op    = OP_READ;
      it.key   = {$urandom, $urandom};
      it.count = COUNT_W'($urandom);
      it.ridx  = ridx;
      it.gap   = paced ? $urandom_range(0, 14) : 0;
      pending_items.push_back(it);
   endtask

   // Random traffic: mostly adds, half of them with keys seen before so that merges
   // are common, and enough fresh keys that the table fills and starts dropping.
   // Reads hit any index, occupied or not. Every 40 items the sender may run with
   // no gaps at all for a stretch.
   task automatic queue_random(int unsigned n);
      logic [COUNT_W-1:0] count;
      bit gaps_on;
      gaps_on = 1'b1;
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       count = '0;
            1:       count = '1;
            default: count = COUNT_W'($urandom);
         endcase
         if ($urandom_range(0, 9) < 3) begin
            queue_read(RIDX_W'($urandom), gaps_on);
         end else if ($urandom_range(0, 1) == 0 && keys_offered.size() != 0) begin
            queue_add(keys_offered[$urandom_range(0, keys_offered.size() - 1)], count, gaps_on);
         end else begin
            queue_add({$urandom, $urandom}, count, gaps_on);
         end
      end
   endtask

   // Waits until every request has been transferred and every
   // expected response has come back. Sampled at the rising edge, where the
   // sender's signals are settled.
   task automatic wait_drained;
      while (pending_items.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Sender: a request stays offered until its transfer; before each new one the
   // sender idles for the number of cycles drawn with it.
   always @(negedge clock) begin : drive_req
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (pending_items.size() != 0 && req_wait < pending_items[0].gap) begin
            req_wait++;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            offered  = pending_items.pop_front();
            req_wait = 0;
            req_tdata  <= {offered.ridx, offered.count, offered.key, offered.op};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: after each response transfer it draws a stall, now and then runs a
   // stretch with no stalls, and once holds off for a long time so that the block's
   // output register fills and it stops taking requests.
   always @(negedge clock) begin : pace_rsp
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fired) begin
            if (!hold_done && results_checked >= HOLD_AFTER) begin
               hold_done = 1'b1;
               hold_left = HOLD_CYCLES;
            end
            if (quiet_left > 0) begin
               quiet_left--;
               stall_left = 0;
            end else begin
               stall_left = $urandom_range(0, 14);
               if ($urandom_range(0, 39) == 0) quiet_left = 25;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Every request transfer is predicted at once; every response transfer is checked
   // against the oldest prediction still waiting.
   always @(posedge clock) begin : check_rsp
      table_result_type seen;
      table_result_type want;
      if (reset) begin
         req_fired <= 1'b0;
         rsp_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         rsp_fired <= rsp_tvalid && rsp_tready;
         if (req_tvalid && req_tready) expected_results.push_back(tally_apply(offered));
         if (rsp_tvalid && rsp_tready) begin
            seen.status  = add_status_type'(rsp_tdata[1:0]);
            seen.index   = rsp_tdata[8:2];
            seen.key     = rsp_tdata[72:9];
            seen.sum     = rsp_tdata[104:73];
            seen.valid   = rsp_tdata[105];
            seen.nonzero = rsp_tdata[106];
            results_checked++;
            if (expected_results.size() == 0) begin
               $display("%0t: response with nothing expected, expected none, actual %0h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = expected_results.pop_front();
               compare_field("add_status", want.status, seen.status);
               compare_field("entry_index", want.index, seen.index);
               compare_field("entry_key", want.key, seen.key);
               compare_field("entry_sum", want.sum, seen.sum);
               compare_field("entry_valid", want.valid, seen.valid);
               compare_field("sum_nonzero", want.nonzero, seen.nonzero);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("keyed_count_aggregator verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: reads of an empty table at both ends of the index range, a
      // zero key with a zero count (occupied but reads as zero sum), the all-ones key,
      // merges with the largest and the smallest count, and reads past the fill level.
      queue_read('0, 1'b1);
      queue_read('1, 1'b1);
      queue_add('0, '0, 1'b1);
      queue_read('0, 1'b1);
      queue_add('1, '1, 1'b1);
      queue_add('0, '1, 1'b1);
      queue_add('1, '0, 1'b1);
      queue_add(64'h8000_0000_0000_0001, 16'd1, 1'b1);
      queue_read(7'd1, 1'b1);
      queue_read(7'd2, 1'b1);
      queue_read(7'd3, 1'b1);
      queue_add(64'h5555_5555_5555_5555, 16'h8000, 1'b1);
      queue_add(64'hAAAA_AAAA_AAAA_AAAA, 16'h7FFF, 1'b1);
      queue_add(64'h8000_0000_0000_0001, 16'hFFFF, 1'b1);
      queue_read(7'd4, 1'b1);
      queue_read(7'd0, 1'b1);
      wait_drained();

      // Random traffic in two phases with a full drain between them. The long
      // receiver hold falls in the first phase while requests are still queued.
      queue_random(300);
      wait_drained();
      queue_random(300);
      wait_drained();

      // Let any late or stray response show up before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d responses never arrived, expected 0, actual %0d", $time,
                  expected_results.size(), expected_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("keyed_count_aggregator verification clean");
      end else begin
         $display("keyed_count_aggregator verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
